### sv/cfd_pkg.sv
// Shared types and constants for the command frame deframer.
// No dependencies; imported by every module of the block.
package cfd_pkg;

   localparam int POS_W = 12;

   localparam logic [7:0] HDR0 = 8'hAA;
   localparam logic [7:0] HDR1 = 8'h55;
   localparam logic [7:0] TRL0 = 8'hA0;
   localparam logic [7:0] TRL1 = 8'h5F;

   localparam logic [POS_W-1:0] POS_COUNT    = 12'd2;
   localparam logic [POS_W-1:0] POS_COMMAND  = 12'd3;
   localparam logic [POS_W-1:0] POS_DEST     = 12'd4;
   localparam logic [POS_W-1:0] POS_INFO     = 12'd5;
   localparam logic [POS_W-1:0] POS_ARG      = 12'd6;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 12'd7;
   localparam logic [POS_W-1:0] REC_LEN      = 12'd8;

   localparam logic [7:0] NODE_ADDR_RESET = 8'd109;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_HDR   = 3'd1,
      STAT_BAD_TRL   = 3'd2,
      STAT_BAD_SUM   = 3'd3,
      STAT_WRONG_NODE = 3'd4
   } status_type;

   typedef enum logic {
      KIND_RECORD  = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] record_index;
      logic [2:0] byte_in_record;
      logic [7:0] record_count;
      logic [7:0] command;
      logic [7:0] dest_node;
      logic [7:0] frame_info;
      logic [7:0] command_data;
      status_type status;
   } rsp_item_type;

endpackage

### sv/cfd_in_reg.sv
// Input register for the deframer: captures one request byte per cycle while the core keeps taking bytes.
// Depends on cfd_pkg.
module cfd_in_reg
   import cfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

### sv/cfd_core.sv
// Frame position tracking, header latching, checksum and result register.
// Depends on cfd_pkg.
module cfd_core
   import cfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_valid,
   input  logic [7:0]   byte_data,
   input  logic [7:0]   node_address,
   output logic         take,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       info_ff, info_in;
   logic [7:0]       arg_ff, arg_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       rx_sum_ff, rx_sum_in;
   logic             hdr_good_ff, hdr_good_in;
   logic             trl_good_ff, trl_good_in;
   logic             valid_ff, valid_in;
   rsp_item_type     item_ff, item_in;

   logic [POS_W-1:0] rec_end;
   logic [POS_W-1:0] rec_off;
   logic             emit;
   rsp_item_type     result;
   status_type       status;

   assign take    = byte_valid && (!valid_ff || out_ready);
   assign rec_end = {1'b0, count_ff, 3'b000} + REC_LEN;
   assign rec_off = pos_ff - REC_LEN;

   always_comb begin
      if (!hdr_good_ff) begin
         status = STAT_BAD_HDR;
      end else if (!(trl_good_ff && byte_data == TRL1)) begin
         status = STAT_BAD_TRL;
      end else if (sum_ff != rx_sum_ff) begin
         status = STAT_BAD_SUM;
      end else if (dest_ff != node_address) begin
         status = STAT_WRONG_NODE;
      end else begin
         status = STAT_OK;
      end
   end

   always_comb begin
      pos_in      = pos_ff + 12'd1;
      count_in    = count_ff;
      command_in  = command_ff;
      dest_in     = dest_ff;
      info_in     = info_ff;
      arg_in      = arg_ff;
      sum_in      = sum_ff;
      rx_sum_in   = rx_sum_ff;
      hdr_good_in = hdr_good_ff;
      trl_good_in = trl_good_ff;
      emit        = 1'b0;
      result.kind           = KIND_RECORD;
      result.data_byte      = byte_data;
      result.record_index   = rec_off[10:3];
      result.byte_in_record = rec_off[2:0];
      result.record_count   = count_ff;
      result.command        = command_ff;
      result.dest_node      = dest_ff;
      result.frame_info     = info_ff;
      result.command_data   = arg_ff;
      result.status         = STAT_OK;

      if (pos_ff == 12'd0) begin
         hdr_good_in = (byte_data == HDR0);
      end else if (pos_ff == 12'd1) begin
         hdr_good_in = hdr_good_ff && (byte_data == HDR1);
      end else if (pos_ff == POS_COUNT) begin
         count_in = byte_data;
         sum_in   = byte_data;
      end else if (pos_ff <= POS_ARG) begin
         case (pos_ff)
            POS_COMMAND: command_in = byte_data;
            POS_DEST:    dest_in    = byte_data;
            POS_INFO:    info_in    = byte_data;
            default:     arg_in     = byte_data;
         endcase
         sum_in = sum_ff + byte_data;
      end else if (pos_ff == POS_CHECKSUM) begin
         rx_sum_in = byte_data;
      end else if (pos_ff < rec_end) begin
         sum_in = sum_ff + byte_data;
         emit   = 1'b1;
      end else if (pos_ff == rec_end) begin
         trl_good_in = (byte_data == TRL0);
      end else begin
         emit                  = 1'b1;
         pos_in                = '0;
         result.kind           = KIND_SUMMARY;
         result.data_byte      = '0;
         result.record_index   = '0;
         result.byte_in_record = '0;
         result.status         = status;
      end
   end

   always_comb begin
      valid_in = valid_ff && !out_ready;
      item_in  = item_ff;
      if (take) begin
         valid_in = emit;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         count_ff    <= '0;
         command_ff  <= '0;
         dest_ff     <= '0;
         info_ff     <= '0;
         arg_ff      <= '0;
         sum_ff      <= '0;
         rx_sum_ff   <= '0;
         hdr_good_ff <= 1'b0;
         trl_good_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (take) begin
            pos_ff      <= pos_in;
            count_ff    <= count_in;
            command_ff  <= command_in;
            dest_ff     <= dest_in;
            info_ff     <= info_in;
            arg_ff      <= arg_in;
            sum_ff      <= sum_in;
            rx_sum_ff   <= rx_sum_in;
            hdr_good_ff <= hdr_good_in;
            trl_good_ff <= trl_good_in;
         end
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### sv/command_frame_deframer_unit.sv
// Top level of the command frame deframer: input register, core, csr.
// Depends on cfd_pkg, cfd_in_reg and cfd_core.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: rx_byte
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tuser: kind, rsp_tdata: result fields
//   csr      in   csr_wr_en              csr_wr_data: node_address
//
// One request per cycle while the response channel is not stalled.
// Each byte passes an input register, one step of position/checksum
// logic, and the response register. A stalled response holds the core;
// the input register still takes one more request meanwhile.
// Synchronous active high reset; node_address resets to 109.
module command_frame_deframer_unit
   import cfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // data_byte, record_index, byte_in_record,
                                    // record_count, command, dest_node,
                                    // frame_info, command_data, status, 2'b0
   output logic        rsp_tuser,   // [0] kind
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // [7:0] node_address
);

   logic         take;
   logic         byte_valid;
   logic [7:0]   byte_data;
   logic [7:0]   node_addr_ff;
   rsp_item_type item;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_addr_ff <= NODE_ADDR_RESET;
      end else if (csr_wr_en) begin
         node_addr_ff <= csr_wr_data;
      end
   end

   cfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   cfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_valid),
      .byte_data    (byte_data),
      .node_address (node_addr_ff),
      .take         (take),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_item     (item)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tdata = {2'b00, item.status, item.command_data, item.frame_info,
                       item.dest_node, item.command, item.record_count,
                       item.byte_in_record, item.record_index, item.data_byte};

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[18:0] == 19'd0))
      else $error("summary carries record data");

   a_record_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[61:59] == STAT_OK))
      else $error("record response with nonzero status");

endmodule
